FILE: src/cddc_pkg.sv
// ----------------------------------------------------------------------------
// cddc_pkg
// Shared types, calendar constants and small lookup functions for the civil
// date / day count converter.
// ----------------------------------------------------------------------------
package cddc_pkg;

  typedef enum logic [1:0] {
    KIND_DATE  = 2'd0,
    KIND_DAYS  = 2'd1,
    KIND_EPOCH = 2'd2
  } kind_t;

  localparam logic [21:0] DAY_MAX = 22'h3FFFFF;

  localparam int unsigned EPOCH_DAYS     = 719468;
  localparam int unsigned ERA_DAYS       = 146097;
  localparam int unsigned CENT_DAYS      = 36524;
  localparam int unsigned QUAD_DAYS      = 1460;
  localparam int unsigned DAYS_PER_YEAR  = 365;
  localparam int unsigned YEARS_PER_ERA  = 400;
  localparam int unsigned YEARS_PER_CENT = 100;

  localparam logic [31:0] EPOCH_FLOOR = 32'd1600000000;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned DAY_POW2     = 7;
  localparam int unsigned DAY_ODD      = SECS_PER_DAY >> DAY_POW2;

  localparam int unsigned OFS_STEP_SECS      = 900;
  localparam int unsigned CFG_RESET_QUARTERS = 48;
  localparam int unsigned OFS_BIAS_SECS      = CFG_RESET_QUARTERS * OFS_STEP_SECS;
  localparam int          OFS_RESET_SECS     =
    int'(CFG_RESET_QUARTERS * OFS_STEP_SECS) - int'(OFS_BIAS_SECS);

  // Reciprocals: floor(x / D) == (x * RCP) >> RSH over the whole input range
  localparam int unsigned RSH_C100 = 21;
  localparam logic [14:0] RCP_C100 = 15'(((64'd1 << RSH_C100) + 64'(YEARS_PER_CENT)
                                         - 64'd1) / 64'(YEARS_PER_CENT));
  localparam int unsigned RSH_DAY  = 36;
  localparam logic [26:0] RCP_DAY  = 27'(((64'd1 << RSH_DAY) + 64'(DAY_ODD) - 64'd1)
                                         / 64'(DAY_ODD));
  localparam int unsigned RSH_ERA  = 41;
  localparam logic [23:0] RCP_ERA  = 24'(((64'd1 << RSH_ERA) + 64'(ERA_DAYS) - 64'd1)
                                         / 64'(ERA_DAYS));
  localparam int unsigned RSH_QUAD = 29;
  localparam logic [18:0] RCP_QUAD = 19'(((64'd1 << RSH_QUAD) + 64'(QUAD_DAYS) - 64'd1)
                                         / 64'(QUAD_DAYS));
  localparam int unsigned RSH_YEAR = 27;
  localparam logic [18:0] RCP_YEAR = 19'(((64'd1 << RSH_YEAR) + 64'(DAYS_PER_YEAR) - 64'd1)
                                         / 64'(DAYS_PER_YEAR));

  localparam int unsigned MONTHS = 12;

  typedef struct packed {
    logic        valid_res;
    logic [21:0] day_count_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  month_length;
  } out_t;

  // First day of year of each month, counted from March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ds;
    case (mp)
      4'd0:    ds = 9'd0;
      4'd1:    ds = 9'd31;
      4'd2:    ds = 9'd61;
      4'd3:    ds = 9'd92;
      4'd4:    ds = 9'd122;
      4'd5:    ds = 9'd153;
      4'd6:    ds = 9'd184;
      4'd7:    ds = 9'd214;
      4'd8:    ds = 9'd245;
      4'd9:    ds = 9'd275;
      4'd10:   ds = 9'd306;
      4'd11:   ds = 9'd337;
      4'd12:   ds = 9'd367;
      default: ds = 9'd0;
    endcase
    return ds;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    case (mo) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/cddc_if.sv
// ----------------------------------------------------------------------------
// cddc channel interfaces
// Request and result channels of the converter, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cddc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [21:0] day_count_in;
  logic [31:0] epoch_seconds;

  modport source (output valid, kind, year, month, day, day_count_in, epoch_seconds,
                  input ready);
  modport sink   (input valid, kind, year, month, day, day_count_in, epoch_seconds,
                  output ready);
endinterface

interface cddc_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [21:0] day_count_out;
  logic [13:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  month_length;

  modport source (output valid, valid_res, day_count_out, year_out, month_out, day_out,
                  month_length, input ready);
  modport sink   (input valid, valid_res, day_count_out, year_out, month_out, day_out,
                  month_length, output ready);
endinterface

FILE: src/civil_date_day_converter.sv
// ----------------------------------------------------------------------------
// civil_date_day_converter
// Converts civil dates, day counts and Unix seconds (with a quarter-hour UTC
// offset) into a day count since 1970-01-01, its date and its month length.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------------
//   in_ch    | in  | valid/ready          | kind, year, month, day,
//            |     |                      | day_count_in, epoch_seconds
//   out_ch   | out | valid/ready          | valid_res, day_count_out, year_out,
//            |     |                      | month_out, day_out, month_length
//   cfg_*    | in  | cfg_we, no wait      | cfg_data = utc_offset_quarters + 48
//
// One request per cycle while out_ch is not stalled; each result passes
// through the 3-stage day-count front and the 9-stage date back end.
// Reset clears every stage valid bit and sets the offset to UTC+0.
// Each stage moves whenever it is empty or its successor moves, so a stalled
// result holds in the output register while bubbles upstream keep filling.
// ----------------------------------------------------------------------------
module civil_date_day_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  cddc_in_if.sink    in_ch,
  cddc_out_if.source out_ch
);

  logic        mid_valid;
  logic        mid_ready;
  logic [21:0] mid_day_count;

  cddc_days u_days (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .dn_valid     (mid_valid),
    .dn_ready     (mid_ready),
    .dn_day_count (mid_day_count)
  );

  cddc_civil u_civil (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (mid_valid),
    .up_ready     (mid_ready),
    .up_day_count (mid_day_count),
    .out_ch       (out_ch)
  );

endmodule

FILE: src/cddc_days.sv
// ----------------------------------------------------------------------------
// cddc_days
// Front pipeline: turns each request into a day count (three stages) and
// holds the UTC offset register.
// ----------------------------------------------------------------------------
module cddc_days (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  cddc_in_if.sink     in_ch,
  output logic        dn_valid,
  input  logic        dn_ready,
  output logic [21:0] dn_day_count
);

  localparam int NS = 3;

  typedef struct packed {
    cddc_pkg::kind_t    kind;
    logic               yneg;
    logic [13:0]        yadj;
    logic signed [10:0] doy;
    logic               plaus;
    logic [25:0]        xq;
    logic [21:0]        dci;
  } s1_t;

  typedef struct packed {
    cddc_pkg::kind_t    kind;
    logic               yneg;
    logic [22:0]        y365;
    logic [11:0]        yq4;
    logic [7:0]         q100;
    logic [5:0]         q400;
    logic signed [10:0] doy;
    logic               plaus;
    logic [16:0]        quot;
    logic [21:0]        dci;
  } s2_t;

  logic signed [17:0] ofs_r, ofs_nxt;
  logic [NS:1]        v_r, v_nxt, vin;
  logic [NS+1:1]      adv;
  s1_t                s1_r, s1_nxt;
  s2_t                s2_r, s2_nxt;
  logic [21:0]        n_r, n_nxt;

  // Offset in seconds, precomputed at the register write
  assign ofs_nxt = 18'(cfg_data) * 18'(cddc_pkg::OFS_STEP_SECS)
                   - 18'(cddc_pkg::OFS_BIAS_SECS);

  // Stage 1: month shift, day of year, local seconds
  always_comb begin : s1_calc
    logic       mlow;
    logic [3:0] mp;
    logic [8:0] moff;
    logic [32:0] loc;
    mlow         = (in_ch.month <= 4'd2);
    mp           = mlow ? in_ch.month + 4'd9 : in_ch.month - 4'd3;
    moff         = cddc_pkg::month_start(mp);
    loc          = {1'b0, in_ch.epoch_seconds} + 33'(ofs_r);
    s1_nxt.kind  = cddc_pkg::kind_t'(in_ch.kind);
    s1_nxt.yneg  = mlow && (in_ch.year == 14'd0);
    s1_nxt.yadj  = mlow ? in_ch.year - 14'd1 : in_ch.year;
    s1_nxt.doy   = 11'(moff) + 11'(in_ch.day) - 11'd1;
    s1_nxt.plaus = (in_ch.epoch_seconds >= cddc_pkg::EPOCH_FLOOR);
    // drop the power-of-two part of the day length here
    s1_nxt.xq    = loc[32:cddc_pkg::DAY_POW2];
    s1_nxt.dci   = in_ch.day_count_in;
  end

  // Stage 2: constant multiplications
  always_comb begin : s2_calc
    logic [28:0] p100;
    logic [26:0] p400;
    logic [52:0] pday;
    p100         = 29'(s1_r.yadj) * 29'(cddc_pkg::RCP_C100);
    p400         = 27'(s1_r.yadj[13:2]) * 27'(cddc_pkg::RCP_C100);
    pday         = 53'(s1_r.xq) * 53'(cddc_pkg::RCP_DAY);
    s2_nxt.kind  = s1_r.kind;
    s2_nxt.yneg  = s1_r.yneg;
    s2_nxt.y365  = 23'(s1_r.yadj) * 23'(cddc_pkg::DAYS_PER_YEAR);
    s2_nxt.yq4   = s1_r.yadj[13:2];
    s2_nxt.q100  = 8'(p100 >> cddc_pkg::RSH_C100);
    s2_nxt.q400  = 6'(p400 >> cddc_pkg::RSH_C100);
    s2_nxt.doy   = s1_r.doy;
    s2_nxt.plaus = s1_r.plaus;
    s2_nxt.quot  = 17'(pday >> cddc_pkg::RSH_DAY);
    s2_nxt.dci   = s1_r.dci;
  end

  // Stage 3: sum, clamp and select by kind
  always_comb begin : s3_calc
    logic signed [24:0] days;
    days = 25'(s2_r.y365) + 25'(s2_r.yq4) - 25'(s2_r.q100) + 25'(s2_r.q400)
           + {{14{s2_r.doy[10]}}, s2_r.doy} - 25'(cddc_pkg::EPOCH_DAYS);
    unique case (s2_r.kind)
      cddc_pkg::KIND_DATE: begin
        if (s2_r.yneg || days[24] || (days == 25'sd0)) begin
          n_nxt = '0;
        end else if (days[23:22] != 2'd0) begin
          n_nxt = cddc_pkg::DAY_MAX;
        end else begin
          n_nxt = days[21:0];
        end
      end
      cddc_pkg::KIND_DAYS:  n_nxt = s2_r.dci;
      cddc_pkg::KIND_EPOCH: n_nxt = s2_r.plaus ? 22'(s2_r.quot) : '0;
      default:              n_nxt = '0;
    endcase
  end

  // Per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    adv[NS+1] = dn_ready;
    for (int s = NS; s >= 1; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
    vin   = {v_r[NS-1:1], in_ch.valid};
    v_nxt = (adv[NS:1] & vin) | (~adv[NS:1] & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      ofs_r <= 18'(cddc_pkg::OFS_RESET_SECS);
    end else begin
      v_r <= v_nxt;
      if (cfg_we) begin
        ofs_r <= ofs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_r <= s1_nxt;
    end
    if (adv[2]) begin
      s2_r <= s2_nxt;
    end
    if (adv[3]) begin
      n_r <= n_nxt;
    end
  end

  assign in_ch.ready  = adv[1];
  assign dn_valid     = v_r[NS];
  assign dn_day_count = n_r;

endmodule

FILE: src/cddc_civil.sv
// ----------------------------------------------------------------------------
// cddc_civil
// Back pipeline: turns a day count into year, month, day and month length
// over nine stages, the last of which is the result register.
// ----------------------------------------------------------------------------
module cddc_civil (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [21:0] up_day_count,
  cddc_out_if.source  out_ch
);

  localparam int NS = 9;

  typedef struct packed {
    logic [21:0] n;
    logic [22:0] z;
  } c1_t;

  typedef struct packed {
    logic [21:0] n;
    logic [22:0] z;
    logic [5:0]  era;
  } c2_t;

  typedef struct packed {
    logic [21:0] n;
    logic [5:0]  era;
    logic [17:0] doe;
  } c3_t;

  typedef struct packed {
    logic [21:0] n;
    logic [5:0]  era;
    logic [17:0] doe;
    logic [6:0]  a;
    logic [2:0]  b;
    logic        c;
  } c4_t;

  typedef struct packed {
    logic [21:0] n;
    logic [5:0]  era;
    logic [17:0] doe;
    logic [17:0] t;
  } c5_t;

  typedef struct packed {
    logic [21:0] n;
    logic [5:0]  era;
    logic [17:0] doe;
    logic [8:0]  yoe;
  } c6_t;

  typedef struct packed {
    logic [21:0] n;
    logic [5:0]  era;
    logic [8:0]  yoe;
    logic [8:0]  doy;
  } c7_t;

  typedef struct packed {
    logic [21:0] n;
    logic [5:0]  era;
    logic [8:0]  ya;
    logic [3:0]  mo;
    logic [4:0]  d;
  } c8_t;

  logic [NS:1]     v_r, v_nxt, vin;
  logic [NS+1:1]   adv;
  c1_t             c1_r, c1_nxt;
  c2_t             c2_r, c2_nxt;
  c3_t             c3_r, c3_nxt;
  c4_t             c4_r, c4_nxt;
  c5_t             c5_r, c5_nxt;
  c6_t             c6_r, c6_nxt;
  c7_t             c7_r, c7_nxt;
  c8_t             c8_r, c8_nxt;
  cddc_pkg::out_t  out_r, out_nxt;

  // Shift to a March-based count from year zero
  always_comb begin
    c1_nxt.n = up_day_count;
    c1_nxt.z = 23'(up_day_count) + 23'(cddc_pkg::EPOCH_DAYS);
  end

  always_comb begin : c2_calc
    logic [46:0] pe;
    pe         = 47'(c1_r.z) * 47'(cddc_pkg::RCP_ERA);
    c2_nxt.n   = c1_r.n;
    c2_nxt.z   = c1_r.z;
    c2_nxt.era = 6'(pe >> cddc_pkg::RSH_ERA);
  end

  always_comb begin
    c3_nxt.n   = c2_r.n;
    c3_nxt.era = c2_r.era;
    c3_nxt.doe = 18'(c2_r.z - 23'(c2_r.era) * 23'(cddc_pkg::ERA_DAYS));
  end

  // Leap-day corrections of the day of era
  always_comb begin : c4_calc
    logic [36:0] pa;
    pa         = 37'(c3_r.doe) * 37'(cddc_pkg::RCP_QUAD);
    c4_nxt.n   = c3_r.n;
    c4_nxt.era = c3_r.era;
    c4_nxt.doe = c3_r.doe;
    c4_nxt.a   = 7'(pa >> cddc_pkg::RSH_QUAD);
    c4_nxt.b   = 3'(c3_r.doe >= 18'(cddc_pkg::CENT_DAYS))
               + 3'(c3_r.doe >= 18'(2 * cddc_pkg::CENT_DAYS))
               + 3'(c3_r.doe >= 18'(3 * cddc_pkg::CENT_DAYS))
               + 3'(c3_r.doe >= 18'(4 * cddc_pkg::CENT_DAYS));
    c4_nxt.c   = (c3_r.doe == 18'(cddc_pkg::ERA_DAYS - 1));
  end

  always_comb begin
    c5_nxt.n   = c4_r.n;
    c5_nxt.era = c4_r.era;
    c5_nxt.doe = c4_r.doe;
    c5_nxt.t   = c4_r.doe - 18'(c4_r.a) + 18'(c4_r.b) - 18'(c4_r.c);
  end

  always_comb begin : c6_calc
    logic [36:0] py;
    py         = 37'(c5_r.t) * 37'(cddc_pkg::RCP_YEAR);
    c6_nxt.n   = c5_r.n;
    c6_nxt.era = c5_r.era;
    c6_nxt.doe = c5_r.doe;
    c6_nxt.yoe = 9'(py >> cddc_pkg::RSH_YEAR);
  end

  always_comb begin : c7_calc
    logic [1:0]  ycent;
    logic [18:0] ystart;
    ycent      = 2'(c6_r.yoe >= 9'd100) + 2'(c6_r.yoe >= 9'd200)
               + 2'(c6_r.yoe >= 9'd300);
    ystart     = 19'(c6_r.yoe) * 19'(cddc_pkg::DAYS_PER_YEAR) + 19'(c6_r.yoe[8:2])
               - 19'(ycent);
    c7_nxt.n   = c6_r.n;
    c7_nxt.era = c6_r.era;
    c7_nxt.yoe = c6_r.yoe;
    c7_nxt.doy = 9'(19'(c6_r.doe) - ystart);
  end

  // Month from day of year, then the January/February year carry
  always_comb begin : c8_calc
    logic [3:0] mp;
    mp = 4'd0;
    for (int i = 1; i < cddc_pkg::MONTHS; i++) begin
      if (c7_r.doy >= cddc_pkg::month_start(4'(i))) begin
        mp = 4'(i);
      end
    end
    c8_nxt.n   = c7_r.n;
    c8_nxt.era = c7_r.era;
    c8_nxt.d   = 5'(c7_r.doy - cddc_pkg::month_start(mp) + 9'd1);
    c8_nxt.mo  = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    c8_nxt.ya  = c7_r.yoe + 9'(c8_nxt.mo <= 4'd2);
  end

  // Result register; the leap rule only needs the year within its era
  always_comb begin : c9_calc
    logic nz;
    logic leap;
    nz   = (c8_r.n != 22'd0);
    leap = (c8_r.ya[1:0] == 2'd0) && (c8_r.ya != 9'd100) && (c8_r.ya != 9'd200)
           && (c8_r.ya != 9'd300);
    out_nxt.valid_res     = nz;
    out_nxt.day_count_out = c8_r.n;
    out_nxt.year_out      = nz ? 14'(c8_r.era) * 14'(cddc_pkg::YEARS_PER_ERA)
                                 + 14'(c8_r.ya) : '0;
    out_nxt.month_out     = nz ? c8_r.mo : '0;
    out_nxt.day_out       = nz ? c8_r.d : '0;
    out_nxt.month_length  = nz ? cddc_pkg::month_len(c8_r.mo, leap) : '0;
  end

  always_comb begin
    adv[NS+1] = out_ch.ready;
    for (int s = NS; s >= 1; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
    vin   = {v_r[NS-1:1], up_valid};
    v_nxt = (adv[NS:1] & vin) | (~adv[NS:1] & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      c1_r <= c1_nxt;
    end
    if (adv[2]) begin
      c2_r <= c2_nxt;
    end
    if (adv[3]) begin
      c3_r <= c3_nxt;
    end
    if (adv[4]) begin
      c4_r <= c4_nxt;
    end
    if (adv[5]) begin
      c5_r <= c5_nxt;
    end
    if (adv[6]) begin
      c6_r <= c6_nxt;
    end
    if (adv[7]) begin
      c7_r <= c7_nxt;
    end
    if (adv[8]) begin
      c8_r <= c8_nxt;
    end
    if (adv[9]) begin
      out_r <= out_nxt;
    end
  end

  assign up_ready             = adv[1];
  assign out_ch.valid         = v_r[NS];
  assign out_ch.valid_res     = out_r.valid_res;
  assign out_ch.day_count_out = out_r.day_count_out;
  assign out_ch.year_out      = out_r.year_out;
  assign out_ch.month_out     = out_r.month_out;
  assign out_ch.day_out       = out_r.day_out;
  assign out_ch.month_length  = out_r.month_length;

  ap_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.valid_res == (out_ch.day_count_out != 22'd0)))
    else $error("valid_res does not follow the day count");

  ap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |->
      (out_ch.year_out == 14'd0) && (out_ch.month_out == 4'd0) &&
      (out_ch.day_out == 5'd0) && (out_ch.month_length == 5'd0))
    else $error("invalid result carries date fields");

  ap_month: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.valid_res |->
      (out_ch.month_out >= 4'd1) && (out_ch.month_out <= 4'd12) &&
      (out_ch.month_length >= 5'd28))
    else $error("month or month length out of range");

  ap_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.valid_res |->
      (out_ch.day_out >= 5'd1) && (out_ch.day_out <= out_ch.month_length))
    else $error("day beyond the month length");

endmodule
